[hw/rtl/psart_pkg.sv]
// Shared types and constants of the per-source anti-replay table.
`timescale 1ns / 1ps

package psart_pkg;

    localparam int IDENT_W  = 53;
    localparam int WO_W     = 32;
    localparam int SERIAL_W = 64;

    localparam logic [4:0] SLOT_LIMIT = 5'd24;
    localparam logic [1:0] TEAM_MAX   = 2'd2;

    // The event being looked up, held steady while its token walks the chain.
    typedef struct packed {
        logic [IDENT_W-1:0]  ident;
        logic [WO_W-1:0]     wo;
        logic [SERIAL_W-1:0] serial;
    } t_query;

    // Token that moves one cell per cycle.
    typedef struct packed {
        logic vld;
        logic done;
        logic acc;
    } t_token;

endpackage

[hw/rtl/psart_cell.sv]
// One table entry of the anti-replay chain with its token stage.
`timescale 1ns / 1ps

module psart_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  psart_pkg::t_query i_query,
    input  psart_pkg::t_token i_tok,
    output psart_pkg::t_token o_tok
);

    logic                               r_valid;
    logic [psart_pkg::SERIAL_W-1:0]     r_serial;
    logic [psart_pkg::IDENT_W-1:0]      r_ident;
    logic [psart_pkg::WO_W-1:0]         r_wo;
    psart_pkg::t_token                  r_tok;
    psart_pkg::t_token                  n_tok;
    logic                               n_valid;
    logic                               w_active;
    logic                               w_match;
    logic                               w_newer;
    logic                               w_claim;
    logic                               w_update;

    assign w_active = i_tok.vld && !i_tok.done;
    assign w_match  = r_valid && (r_ident == i_query.ident) && (r_wo == i_query.wo);
    assign w_newer  = i_query.serial > r_serial;
    assign w_claim  = w_active && !r_valid;
    assign w_update = w_active && w_match && w_newer;

    always_comb begin
        n_tok = i_tok;
        if (w_active && w_match) begin
            n_tok.done = 1'b1;
            n_tok.acc  = w_newer;
        end else if (w_claim) begin
            n_tok.done = 1'b1;
            n_tok.acc  = 1'b1;
        end
        n_valid = r_valid;
        if (i_clear) begin
            n_valid = 1'b0;
        end else if (w_claim) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_claim || w_update) begin
            r_serial <= i_query.serial;
        end
        if (w_claim) begin
            r_ident <= i_query.ident;
            r_wo    <= i_query.wo;
        end
    end

    assign o_tok = r_tok;

endmodule

[hw/rtl/per_source_anti_replay_table.sv]
// Top level of the per-source anti-replay table: screening, epoch and cell chain.
`timescale 1ns / 1ps

// Each item is one event: an actor key, team, weapon, object and serial.
// An item is taken at a rising edge where start is high and busy is low.
// The single result (o_accepted) shows for exactly one cycle, marked by
// o_result_valid; the receiver cannot stall it, so nothing ever waits.
// Events with a bad key, a bad team, a zero serial or an older epoch are
// screened at the input: their reject strobe follows in the next cycle and
// busy never rises, so another item can be taken right away.
// Any other event raises busy and sends a token down a row of
// CHANNEL_COUNT cells, one cell per cycle. Live entries always form a
// prefix of the row, because entries are only freed all together, so the
// first cell that either matches or is free settles the item. The token
// passes the inject register, every cell register and then the result
// register, where the strobe shows and busy falls; no new item is taken
// while a token is in the row.
// A newer epoch frees every cell at the accepting edge (valid bits only)
// before the token starts. Reset clears the epoch, all valid bits, busy
// and the result strobe; no clearing pass is needed.
module per_source_anti_replay_table #(
    parameter int CHANNEL_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_actor_epoch,
    input  logic [4:0]  i_actor_slot,
    input  logic [15:0] i_actor_instance,
    input  logic [15:0] i_actor_character,
    input  logic [15:0] i_actor_life,
    input  logic [1:0]  i_team_id,
    input  logic [15:0] i_weapon_id,
    input  logic [15:0] i_object_id,
    input  logic [63:0] i_serial_value,
    output logic        o_result_valid,
    output logic        o_accepted
);

    logic              r_busy;
    logic              r_inj;
    logic              r_out_vld;
    logic              r_acc;
    logic [31:0]       r_epoch;
    psart_pkg::t_query r_query;
    psart_pkg::t_token w_tok [CHANNEL_COUNT+1];

    logic w_accept;
    logic w_key_bad;
    logic w_older;
    logic w_reject;
    logic w_clear;

    assign w_accept = start && !r_busy;

    // Screening that needs no table lookup.
    assign w_key_bad = (i_actor_epoch == 32'd0) || (i_actor_slot >= psart_pkg::SLOT_LIMIT) ||
                       (i_actor_instance == 16'd0) || (i_actor_character == 16'd0) ||
                       (i_actor_life == 16'd0) || (i_serial_value == 64'd0) ||
                       (i_team_id > psart_pkg::TEAM_MAX);
    assign w_older  = (r_epoch != 32'd0) && (i_actor_epoch < r_epoch);
    assign w_reject = w_key_bad || w_older;
    assign w_clear  = w_accept && !w_reject && (i_actor_epoch != r_epoch);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_inj     <= 1'b0;
            r_out_vld <= 1'b0;
            r_epoch   <= '0;
        end else begin
            r_inj     <= w_accept && !w_reject;
            r_out_vld <= (w_accept && w_reject) || w_tok[CHANNEL_COUNT].vld;
            if (w_accept && !w_reject) begin
                r_busy <= 1'b1;
            end else if (w_tok[CHANNEL_COUNT].vld) begin
                r_busy <= 1'b0;
            end
            if (w_clear) begin
                r_epoch <= i_actor_epoch;
            end
        end
    end

    // The query stays put while its token walks; only one item is in flight.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_query.ident  <= {i_actor_slot, i_actor_instance, i_actor_character,
                               i_actor_life};
            r_query.wo     <= {i_weapon_id, i_object_id};
            r_query.serial <= i_serial_value;
        end
        // A screened reject reports zero; otherwise the token that leaves the
        // row tells whether some cell took the event. A token still open at
        // the end means the table is full.
        r_acc <= w_accept ? 1'b0 : (w_tok[CHANNEL_COUNT].done && w_tok[CHANNEL_COUNT].acc);
    end

    assign w_tok[0] = '{vld: r_inj, done: 1'b0, acc: 1'b0};

    for (genvar g = 0; g < CHANNEL_COUNT; g++) begin : g_cell
        psart_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (w_clear),
            .i_query (r_query),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign busy           = r_busy;
    assign o_result_valid = r_out_vld;
    assign o_accepted     = r_acc;

endmodule

[hw/rtl/psart_checker.sv]
// Port-level checks of the anti-replay table and their binding.
`timescale 1ns / 1ps

module psart_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [4:0]  i_actor_slot,
    input logic [1:0]  i_team_id,
    input logic [63:0] i_serial_value,
    input logic        o_result_valid,
    input logic        o_accepted
);

    // A lookup in progress never overlaps a result strobe.
    a_no_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_result_valid)
        else $error("result strobe while a lookup is in progress");

    // A zero serial is rejected in the very next cycle.
    a_zero_serial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_serial_value == 64'd0)) |=> (o_result_valid && !o_accepted))
        else $error("zero serial not rejected at once");

    // A slot of 24 or more is rejected in the very next cycle.
    a_bad_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_actor_slot[4:3] == 2'b11)) |=> (o_result_valid && !o_accepted))
        else $error("invalid slot not rejected at once");

    // The unused team code is rejected in the very next cycle.
    a_bad_team: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_team_id == 2'd3)) |=> (o_result_valid && !o_accepted))
        else $error("invalid team not rejected at once");

    // Busy only rises after an item was taken.
    a_busy_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an item");

endmodule

bind per_source_anti_replay_table psart_checker u_psart_checker (.*);

[tb/tb_top.sv]
// Self-checking testbench of the per-source anti-replay table.
`timescale 1ns / 1ps

module tb_top;

    localparam int N_ENTRIES   = 16;
    localparam int POOL_SIZE   = 20;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PRINT_LIMIT = 100;

    // One event as the sender sees it.
    typedef struct packed {
        logic [31:0] epoch;
        logic [4:0]  slot;
        logic [15:0] inst;
        logic [15:0] chr;
        logic [15:0] life;
        logic [1:0]  team;
        logic [15:0] weapon;
        logic [15:0] object;
        logic [63:0] serial;
    } t_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] actor_epoch = '0;
    logic [4:0]  actor_slot = '0;
    logic [15:0] actor_instance = '0;
    logic [15:0] actor_character = '0;
    logic [15:0] actor_life = '0;
    logic [1:0]  team_id = '0;
    logic [15:0] weapon_id = '0;
    logic [15:0] object_id = '0;
    logic [63:0] serial_value = '0;
    logic        o_result_valid;
    logic        o_accepted;

    // Shadow copy of the table, updated as each event is taken.
    logic [31:0]                    cur_epoch = '0;
    logic [psart_pkg::SERIAL_W-1:0] tbl_serial [N_ENTRIES];
    logic [psart_pkg::IDENT_W-1:0]  tbl_ident  [N_ENTRIES];
    logic [psart_pkg::WO_W-1:0]     tbl_wo     [N_ENTRIES];

    // Verdicts still owed by the block, oldest first.
    bit          verdict_q [$];
    bit          want_verdict;
    int          fail_count = 0;
    int          print_count = 0;
    int          cycle_count = 0;

    // Channels that the random traffic draws from, and the last serial sent on each.
    t_event      pool_ch   [POOL_SIZE];
    logic [63:0] pool_last [POOL_SIZE];

    always #4 i_clk = ~i_clk;

    per_source_anti_replay_table #(
        .CHANNEL_COUNT(N_ENTRIES)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_actor_epoch     (actor_epoch),
        .i_actor_slot      (actor_slot),
        .i_actor_instance  (actor_instance),
        .i_actor_character (actor_character),
        .i_actor_life      (actor_life),
        .i_team_id         (team_id),
        .i_weapon_id       (weapon_id),
        .i_object_id       (object_id),
        .i_serial_value    (serial_value),
        .o_result_valid    (o_result_valid),
        .o_accepted        (o_accepted)
    );

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (print_count < PRINT_LIMIT) begin
            print_count++;
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    // Appends one owed verdict behind the ones already waiting.
    task automatic owe_verdict(input bit verdict);
        verdict_q = {verdict_q, verdict};
    endtask

    // Decides one event against the shadow table and applies its effect.
    function automatic bit judge_event(input t_event ev);
        logic [psart_pkg::IDENT_W-1:0] id;
        logic [psart_pkg::WO_W-1:0]    wo;
        if (ev.epoch == 0 || ev.slot >= psart_pkg::SLOT_LIMIT || ev.inst == 0 ||
            ev.chr == 0 || ev.life == 0)
            return 1'b0;
        if (ev.serial == 0 || ev.team > psart_pkg::TEAM_MAX)
            return 1'b0;
        if (cur_epoch != 0 && ev.epoch < cur_epoch)
            return 1'b0;
        // A newer epoch frees every entry before the lookup.
        if (ev.epoch != cur_epoch) begin
            for (int i = 0; i < N_ENTRIES; i++)
                tbl_serial[i] = '0;
            cur_epoch = ev.epoch;
        end
        id = {ev.slot, ev.inst, ev.chr, ev.life};
        wo = {ev.weapon, ev.object};
        for (int i = 0; i < N_ENTRIES; i++) begin
            if (tbl_serial[i] != 0 && tbl_ident[i] == id && tbl_wo[i] == wo) begin
                if (ev.serial <= tbl_serial[i])
                    return 1'b0;
                tbl_serial[i] = ev.serial;
                return 1'b1;
            end
        end
        // New channel: lowest free entry, or a reject when the table is full.
        for (int i = 0; i < N_ENTRIES; i++) begin
            if (tbl_serial[i] == 0) begin
                tbl_serial[i] = ev.serial;
                tbl_ident[i]  = id;
                tbl_wo[i]     = wo;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_event mk_event(input logic [31:0] epoch, input logic [4:0] slot,
                                        input logic [15:0] inst, input logic [15:0] chr,
                                        input logic [15:0] life, input logic [1:0] team,
                                        input logic [15:0] weapon,
                                        input logic [15:0] object,
                                        input logic [63:0] serial);
        t_event ev;
        ev.epoch  = epoch;
        ev.slot   = slot;
        ev.inst   = inst;
        ev.chr    = chr;
        ev.life   = life;
        ev.team   = team;
        ev.weapon = weapon;
        ev.object = object;
        ev.serial = serial;
        return ev;
    endfunction

    // Presents one event and returns at the edge that takes it. Start is left
    // high so that a following event can go out back to back.
    task automatic send_event(input t_event ev);
        bit verdict;
        start           <= 1'b1;
        actor_epoch     <= ev.epoch;
        actor_slot      <= ev.slot;
        actor_instance  <= ev.inst;
        actor_character <= ev.chr;
        actor_life      <= ev.life;
        team_id         <= ev.team;
        weapon_id       <= ev.weapon;
        object_id       <= ev.object;
        serial_value    <= ev.serial;
        do @(posedge i_clk); while (busy);
        verdict = judge_event(ev);
        owe_verdict(verdict);
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Sender pause until every owed verdict has come back.
    task automatic drain_verdicts();
        start <= 1'b0;
        do @(posedge i_clk); while (verdict_q.size() != 0);
    endtask

    // Each verdict is compared with the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("verdict strobed with no event outstanding");
            end else begin
                want_verdict = verdict_q.pop_front();
                if (o_accepted !== want_verdict)
                    report_mismatch($sformatf("accepted %b, expected %b",
                                              o_accepted, want_verdict));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d verdicts outstanding",
                     cycle_count, verdict_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic apply_reset();
        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // One channel: first use, equal serial, then the largest serial.
    task automatic test_basic_channel();
        t_event a;
        a = mk_event(32'd5, 5'd23, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd2, 16'hFFFF,
                     16'h0000, 64'd100);
        send_event(a);
        send_event(a);
        a.serial = 64'hFFFF_FFFF_FFFF_FFFF;
        send_event(a);
    endtask

    // Every screening reason, each on an otherwise valid event.
    task automatic test_screening();
        t_event b;
        t_event e;
        b = mk_event(32'd5, 5'd0, 16'd1, 16'd1, 16'd1, 2'd0, 16'h0000, 16'hFFFF, 64'd1);
        e = b; e.epoch = 32'd0;   send_event(e);
        e = b; e.slot = 5'd24;    send_event(e);
        e = b; e.slot = 5'd31;    send_event(e);
        e = b; e.inst = 16'd0;    send_event(e);
        e = b; e.chr = 16'd0;     send_event(e);
        e = b; e.life = 16'd0;    send_event(e);
        e = b; e.team = 2'd3;     send_event(e);
        e = b; e.serial = 64'd0;  send_event(e);
        e = b; e.epoch = 32'd4;   send_event(e);
    endtask

    // A newer epoch empties the table, so a small serial is fresh again.
    task automatic test_epoch_change();
        drain_verdicts();
        send_event(mk_event(32'd6, 5'd23, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd1, 16'hFFFF,
                            16'h0000, 64'd1));
    endtask

    // Fill the table, see a new channel turned away, and a known one still served.
    task automatic test_full_table();
        for (int i = 1; i <= N_ENTRIES; i++)
            send_event(mk_event(32'd6, 5'd7, 16'd1, 16'd2, 16'd3, 2'd1, 16'h1234,
                                i[15:0], 64'd10));
        send_event(mk_event(32'd6, 5'd23, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd0, 16'hFFFF,
                            16'h0000, 64'd2));
    endtask

    // Draws a valid channel identity; some are near copies of another channel
    // so that a single differing field must keep them apart.
    task automatic make_channel(input int k);
        int j;
        j = $urandom_range(0, POOL_SIZE - 1);
        if (j != k && $urandom_range(0, 99) < 30) begin
            pool_ch[k] = pool_ch[j];
            case ($urandom_range(0, 5))
                0: pool_ch[k].slot   = 5'($urandom_range(0, 23));
                1: pool_ch[k].inst   = 16'($urandom_range(1, 65535));
                2: pool_ch[k].chr    = 16'($urandom_range(1, 65535));
                3: pool_ch[k].life   = 16'($urandom_range(1, 65535));
                4: pool_ch[k].weapon = 16'($urandom);
                default: pool_ch[k].object = 16'($urandom);
            endcase
        end else begin
            pool_ch[k] = mk_event(32'd0, 5'($urandom_range(0, 23)),
                                  16'($urandom_range(1, 65535)),
                                  16'($urandom_range(1, 65535)),
                                  16'($urandom_range(1, 65535)),
                                  2'd0, 16'($urandom), 16'($urandom), 64'd0);
        end
    endtask

    function automatic logic [63:0] next_serial(input logic [63:0] last);
        logic [64:0] sum;
        logic [63:0] jump;
        jump = {$urandom, $urandom};
        if ($urandom_range(0, 99) < 5 && jump > last)
            return jump;
        sum = {1'b0, last} + 65'($urandom_range(1, 100));
        return sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
    endfunction

    // Mostly well-formed traffic on a small set of channels, so that entries
    // match, fill up and get freed by epoch steps; the rest is broken events.
    task automatic test_random_traffic(input int count, input int idle_pct);
        t_event       ev;
        logic [191:0] raw;
        int           k;
        int           r;
        int           gap;
        for (int n = 0; n < count; n++) begin
            gap = 0;
            while ($urandom_range(0, 99) < idle_pct)
                gap++;
            if (gap > 0)
                hold_off(gap);
            r = $urandom_range(0, 99);
            // The first event of a phase draws a fresh epoch while the current one is below 32'hFFFF_F000.
            if ((n == 0 || r < 2) && cur_epoch < 32'hFFFF_F000) begin
                for (int i = 0; i < POOL_SIZE; i++) begin
                    pool_last[i] = '0;
                    if ($urandom_range(0, 3) == 0)
                        make_channel(i);
                end
                k = $urandom_range(0, POOL_SIZE - 1);
                ev = pool_ch[k];
                ev.epoch = cur_epoch + $urandom_range(1, 1000);
                ev.serial = next_serial(pool_last[k]);
                pool_last[k] = ev.serial;
            end else begin
                k = $urandom_range(0, POOL_SIZE - 1);
                ev = pool_ch[k];
                ev.epoch = cur_epoch;
                if ($urandom_range(0, 99) < 10 && pool_last[k] != 0) begin
                    ev.serial = (pool_last[k] > 3) ?
                                pool_last[k] - 64'($urandom_range(0, 3)) : pool_last[k];
                end else begin
                    ev.serial = next_serial(pool_last[k]);
                    pool_last[k] = ev.serial;
                end
            end
            ev.team = 2'($urandom_range(0, 2));
            if (r >= 2 && r < 14) begin
                case ($urandom_range(0, 8))
                    0: ev.epoch  = 32'd0;
                    1: ev.slot   = 5'($urandom_range(24, 31));
                    2: ev.inst   = 16'd0;
                    3: ev.chr    = 16'd0;
                    4: ev.life   = 16'd0;
                    5: ev.team   = 2'd3;
                    6: ev.serial = 64'd0;
                    7: ev.epoch  = (cur_epoch > 1) ? $urandom_range(1, cur_epoch - 1) : 32'd0;
                    default: begin
                        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
                        ev = raw[$bits(t_event)-1:0];
                        if ($urandom_range(0, 1))
                            ev.epoch = cur_epoch;
                    end
                endcase
            end
            send_event(ev);
        end
        drain_verdicts();
    endtask

    // The last epoch there is, with the largest serial, then an older epoch.
    task automatic test_epoch_ceiling();
        t_event c;
        c = mk_event(32'hFFFF_FFFF, 5'd12, 16'h8001, 16'h7FFE, 16'h0001, 2'd2, 16'h0000,
                     16'h0000, 64'hFFFF_FFFF_FFFF_FFFF);
        send_event(c);
        send_event(c);
        c.epoch = 32'hFFFF_FFFE;
        c.serial = 64'd5;
        send_event(c);
    endtask

    initial begin
        for (int i = 0; i < N_ENTRIES; i++)
            tbl_serial[i] = '0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            make_channel(i);
            pool_last[i] = '0;
        end
        apply_reset();
        test_basic_channel();
        test_screening();
        test_epoch_change();
        test_full_table();
        drain_verdicts();
        // Sender idles often, then very often, then never.
        test_random_traffic(560, 14);
        test_random_traffic(560, 60);
        test_random_traffic(580, 0);
        test_epoch_ceiling();
        drain_verdicts();
        hold_off(N_ENTRIES + 4);
        if (fail_count == 0 && verdict_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
